[hdl/proxy_v2_tcp_header_insert_rewrite_defines.svh]
// Assertion macros for the proxy v2 header rewrite RTL.
`ifndef PROXY_V2_TCP_HEADER_INSERT_REWRITE_DEFINES_SVH
`define PROXY_V2_TCP_HEADER_INSERT_REWRITE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only outside reset.
`define PPV2_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("ppv2 assertion failed");
// Checked at every edge, reset included.
`define PPV2_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("ppv2 assertion failed");
`else
`define PPV2_ASSERT(label, clk, rstn, prop)
`define PPV2_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[hdl/ppv2_pkg.sv]
// Types and constants of the proxy v2 header rewrite block.
package ppv2_pkg;

    typedef logic [2:0] action_t;
    typedef logic [3:0] res_idx_t;

    localparam action_t ACT_PASS   = 3'd0;
    localparam action_t ACT_DROP   = 3'd1;
    localparam action_t ACT_MSS    = 3'd2;
    localparam action_t ACT_INSERT = 3'd3;
    localparam action_t ACT_SEQ    = 3'd4;
    localparam action_t ACT_ACK    = 3'd5;

    localparam logic [5:0] HLEN_V4 = 6'd28;
    localparam logic [5:0] HLEN_V6 = 6'd52;

    localparam logic [31:0] SIG_WORD0  = 32'h0D0A0D0A;
    localparam logic [31:0] SIG_WORD1  = 32'h000D0A51;
    localparam logic [31:0] SIG_WORD2  = 32'h5549540A;
    localparam logic [31:0] FAM_WORD_V4 = 32'h2111000C;
    localparam logic [31:0] FAM_WORD_V6 = 32'h21210024;

    // Index of the final result of an insert: the action result plus the words.
    localparam res_idx_t LAST_IDX_V4 = 4'd7;
    localparam res_idx_t LAST_IDX_V6 = 4'd13;

endpackage

[hdl/proxy_v2_tcp_header_insert_rewrite.sv]
// Per-packet TCP rewrite decision with PROXY v2 header word generation.
//
//  Channel | Ports  | Content
//  --------+--------+---------------------------------------------------
//  input   | s_*    | one request per TCP packet: flags, numbers, addresses
//  result  | m_*    | action result, then header words for an insert
//
// Each request is held in the input register and gives one result per cycle
// unless m_ready stalls, through the single result register: one result for
// most packets, 8 (IPv4) or 14 (IPv6) for an insert. A new request is taken in
// the cycle the last result of the current one moves to the result register.
// Reset clears the valid flags and the word counter. A stall on m_ready holds
// the result register and, through it, the input register.
`include "proxy_v2_tcp_header_insert_rewrite_defines.svh"

module proxy_v2_tcp_header_insert_rewrite (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic                 s_is_ipv6,
    input  logic [3:0]           s_tcp_flags,
    input  logic [31:0]          s_seq_num,
    input  logic [31:0]          s_ack_num,
    input  logic [15:0]          s_payload_len,
    input  logic [31:0]          s_first_data_ack,
    input  logic [31:0]          s_port_pair,
    input  logic [63:0]          s_src_addr_hi,
    input  logic [63:0]          s_src_addr_lo,
    input  logic [63:0]          s_dst_addr_hi,
    input  logic [63:0]          s_dst_addr_lo,
    output logic                 m_valid,
    input  logic                 m_ready,
    output ppv2_pkg::action_t    m_action,
    output logic [31:0]          m_new_number,
    output logic [5:0]           m_length_delta,
    output logic                 m_is_header_word,
    output logic [31:0]          m_header_word,
    output logic                 m_last
);
    import ppv2_pkg::*;

    logic        in_valid_reg;
    logic        op_reg;
    logic        v6_reg;
    logic [3:0]  flags_reg;
    logic [31:0] seq_reg;
    logic [31:0] ack_reg;
    logic [15:0] plen_reg;
    logic [31:0] fdack_reg;
    logic [31:0] ports_reg;
    logic [63:0] sh_reg;
    logic [63:0] sl_reg;
    logic [63:0] dh_reg;
    logic [63:0] dl_reg;
    res_idx_t    idx_reg;

    logic        m_valid_reg;
    action_t     m_action_reg;
    logic [31:0] m_new_number_reg;
    logic [5:0]  m_length_delta_reg;
    logic        m_is_header_word_reg;
    logic [31:0] m_header_word_reg;
    logic        m_last_reg;

    logic        load;
    logic        syn;
    logic        ackf;
    logic        rst;
    logic        fin;
    logic [5:0]  hlen;
    action_t     act_next;
    logic [31:0] number_next;
    logic [5:0]  delta_next;
    logic        isw_next;
    logic [31:0] word_next;
    logic        last_next;
    res_idx_t    last_idx;

    assign syn  = flags_reg[0];
    assign ackf = flags_reg[1];
    assign rst  = flags_reg[2];
    assign fin  = flags_reg[3];
    assign hlen = v6_reg ? HLEN_V6 : HLEN_V4;
    assign last_idx = v6_reg ? LAST_IDX_V6 : LAST_IDX_V4;

    always_comb begin
        number_next = 32'd0;
        delta_next  = hlen;
        priority if (op_reg) begin
            if (syn && ackf) begin
                act_next = ACT_MSS;
            end else begin
                act_next    = ACT_ACK;
                number_next = ack_reg - {26'd0, hlen};
            end
        end else if (syn && !ackf) begin
            if (plen_reg != 16'd0) begin
                act_next   = ACT_DROP;
                delta_next = 6'd0;
            end else begin
                act_next = ACT_MSS;
            end
        end else if (ack_reg == fdack_reg && !syn && !rst && !fin) begin
            if (plen_reg == 16'd0) begin
                act_next   = ACT_PASS;
                delta_next = 6'd0;
            end else begin
                act_next = ACT_INSERT;
            end
        end else begin
            act_next    = ACT_SEQ;
            number_next = seq_reg + {26'd0, hlen};
        end
    end

    always_comb begin
        unique case (idx_reg)
            4'd1:    word_next = SIG_WORD0;
            4'd2:    word_next = SIG_WORD1;
            4'd3:    word_next = SIG_WORD2;
            4'd4:    word_next = v6_reg ? FAM_WORD_V6 : FAM_WORD_V4;
            4'd5:    word_next = v6_reg ? sh_reg[63:32] : sl_reg[31:0];
            4'd6:    word_next = v6_reg ? sh_reg[31:0] : dl_reg[31:0];
            4'd7:    word_next = v6_reg ? sl_reg[63:32] : ports_reg;
            4'd8:    word_next = sl_reg[31:0];
            4'd9:    word_next = dh_reg[63:32];
            4'd10:   word_next = dh_reg[31:0];
            4'd11:   word_next = dl_reg[63:32];
            4'd12:   word_next = dl_reg[31:0];
            4'd13:   word_next = ports_reg;
            default: word_next = 32'd0;
        endcase
    end

    assign isw_next  = (act_next == ACT_INSERT) && (idx_reg != 4'd0);
    assign last_next = (act_next != ACT_INSERT) || (idx_reg == last_idx);

    assign load    = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || (load && last_next);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (load && last_next) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg    <= s_op;
            v6_reg    <= s_is_ipv6;
            flags_reg <= s_tcp_flags;
            seq_reg   <= s_seq_num;
            ack_reg   <= s_ack_num;
            plen_reg  <= s_payload_len;
            fdack_reg <= s_first_data_ack;
            ports_reg <= s_port_pair;
            sh_reg    <= s_src_addr_hi;
            sl_reg    <= s_src_addr_lo;
            dh_reg    <= s_dst_addr_hi;
            dl_reg    <= s_dst_addr_lo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 4'd0;
            m_valid_reg <= 1'b0;
        end else if (load) begin
            idx_reg     <= last_next ? 4'd0 : idx_reg + 4'd1;
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_action_reg         <= act_next;
            m_new_number_reg     <= number_next;
            m_length_delta_reg   <= delta_next;
            m_is_header_word_reg <= isw_next;
            m_header_word_reg    <= isw_next ? word_next : 32'd0;
            m_last_reg           <= last_next;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_action         = m_action_reg;
    assign m_new_number     = m_new_number_reg;
    assign m_length_delta   = m_length_delta_reg;
    assign m_is_header_word = m_is_header_word_reg;
    assign m_header_word    = m_header_word_reg;
    assign m_last           = m_last_reg;

    `PPV2_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_valid_reg && !in_valid_reg)
    `PPV2_ASSERT(a_word_needs_item, aclk, aresetn, idx_reg != 4'd0 |-> in_valid_reg)
    `PPV2_ASSERT(a_idx_range, aclk, aresetn, idx_reg <= LAST_IDX_V6)
    `PPV2_ASSERT(a_word_is_insert, aclk, aresetn, m_valid_reg && m_is_header_word_reg |-> m_action_reg == ACT_INSERT)
    `PPV2_ASSERT(a_open_is_insert, aclk, aresetn, m_valid_reg && !m_last_reg |-> m_action_reg == ACT_INSERT && in_valid_reg)

endmodule
